[src/cpsm_pkg.sv]
// ----------------------------------------------------------------------------
// cpsm_pkg
// Shared types and constants for the capture-period speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsm_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 5;
    localparam int unsigned TIMER_BITS_DEF   = 16;

    localparam int unsigned CHANNEL_W = 3;
    localparam int unsigned CAPTURE_W = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OVF_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // input op codes
    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CAPTURE  = 1'b1;

    // overflow source select
    localparam logic TIMER_WHEEL  = 1'b0;
    localparam logic TIMER_ENGINE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_CONST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENGINE_CONST = 1'd1;

    localparam logic [DATA_W-1:0] WHEEL_CONST_RESET  = 32'd467575834;
    localparam logic [DATA_W-1:0] ENGINE_CONST_RESET = 32'd155858611;

    typedef struct packed {
        logic                 op;
        logic                 timer_sel;
        logic [CHANNEL_W-1:0] channel;
        logic [CAPTURE_W-1:0] capture_value;
    } in_item_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [DATA_W-1:0]    period_ticks;
        logic [DATA_W-1:0]    speed_q8;
        logic                 zero_period;
    } out_item_t;

endpackage

`default_nettype wire

[src/capture_period_speed_meter_core.sv]
// ----------------------------------------------------------------------------
// capture_period_speed_meter_core
// Capture-period speed meter: per-channel capture history in a small RAM,
// overflow-extended period, speed by serial division.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries events: timer overflows (op = 0) and capture edges (op = 1).
//   An overflow transfer yields no result; it bumps the wheel or engine
//   overflow counter. A capture on a channel beyond the channel count is
//   dropped.
//   A valid capture takes a RAM read (ST_EXEC follows), the divider start,
//   the serial divide, the divider's done flag, then ST_HOLD loads the m_*
//   output register. One capture is in flight at a time: s_ready is low
//   from ST_EXEC until ST_HOLD hands off its result.
//   A zero period skips the divider: ST_EXEC goes straight to ST_HOLD, and
//   the next event can enter once ST_HOLD has loaded the output register.
//   The output register lets the next event enter while a result waits; a
//   stalled receiver stops the block only when a second result is done.
//   Reset (aresetn low, synchronous) clears the overflow counters, the entry
//   valid bits (so all channel entries read as zero) and loads the default
//   speed constants. cfg_* writes take effect at once, no handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_speed_meter_core #(
    parameter int unsigned NUM_CHANNELS = cpsm_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned TIMER_BITS   = cpsm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // event input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire cpsm_pkg::in_item_t             s_data,
    // result output
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output cpsm_pkg::out_item_t                 m_data,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [cpsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cpsm_pkg::DATA_W-1:0]    cfg_wdata
);

    localparam int unsigned CH_W    = $clog2(NUM_CHANNELS);
    localparam int unsigned OVF_W   = cpsm_pkg::OVF_W;
    localparam int unsigned DW      = cpsm_pkg::DATA_W;
    // entry layout: {phase, latched, base, last, prev}
    localparam int unsigned ENTRY_W = 2 * TIMER_BITS + 2 * OVF_W + 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                  phase;
        logic [OVF_W-1:0]      latched;
        logic [OVF_W-1:0]      base;
        logic [TIMER_BITS-1:0] last;
        logic [TIMER_BITS-1:0] prev;
    } entry_t;

    state_t                          state_reg, state_next;
    logic [DW-1:0]                   wheel_const_reg, engine_const_reg;
    logic [OVF_W-1:0]                wheel_ovf_reg, engine_ovf_reg;
    logic [NUM_CHANNELS-1:0]         valid_reg, valid_next;
    logic [cpsm_pkg::CHANNEL_W-1:0]  chan_reg, chan_next;
    logic [TIMER_BITS-1:0]           cap_reg, cap_next;
    logic [DW-1:0]                   ticks_reg, ticks_next;
    logic                            zero_reg, zero_next;
    logic                            m_valid_reg, m_valid_next;
    cpsm_pkg::out_item_t             m_data_reg, m_data_next;

    logic [CH_W-1:0]                 idx;
    logic [CH_W-1:0]                 in_idx;
    logic                            in_range;
    logic                            accept;
    logic [ENTRY_W-1:0]              rd_word;
    entry_t                          cur;
    entry_t                          upd;
    logic                            ram_we;
    logic [OVF_W-1:0]                global_ovf;
    logic [OVF_W-1:0]                count_now;
    logic [63:0]                     lat_shift;
    logic [DW-1:0]                   ticks;
    logic [DW-1:0]                   konst;
    logic                            div_start;
    logic                            div_busy;
    logic                            div_done;
    logic [DW-1:0]                   div_quo;

    assign idx      = CH_W'(chan_reg);
    assign in_idx   = CH_W'(s_data.channel);
    assign in_range = 32'(s_data.channel) < 32'(NUM_CHANNELS);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    // Per-channel capture history. Read address follows the input so the
    // entry arrives in ST_EXEC; written back in the same ST_EXEC cycle.
    cpsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (upd),
        .raddr (in_idx),
        .rdata (rd_word)
    );

    cpsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (konst),
        .divisor  (ticks_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Read-modify-write of one channel entry. Overflow counts are kept as a
    // free-running counter per timer plus a per-channel base:
    // count = global - base (mod 256). Clearing the count = base <= global.
    always_comb begin
        cur        = valid_reg[idx] ? entry_t'(rd_word) : '0;
        global_ovf = (idx == LAST_CH) ? engine_ovf_reg : wheel_ovf_reg;
        count_now  = global_ovf - cur.base;
        upd        = cur;
        if (!cur.phase) begin
            upd.base  = global_ovf;   // first edge clears the count
            upd.phase = 1'b1;
        end else begin
            upd.latched = count_now;  // a capture in phase 1 latches it
            upd.phase   = 1'b0;
        end
        upd.prev  = cur.last;
        upd.last  = cap_reg;
        lat_shift = 64'(upd.latched) << TIMER_BITS;
        ticks     = 32'(upd.last) - 32'(upd.prev) + lat_shift[31:0];
        konst     = (idx == LAST_CH) ? engine_const_reg : wheel_const_reg;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        chan_next    = chan_reg;
        cap_next     = cap_reg;
        ticks_next   = ticks_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.op == cpsm_pkg::OP_CAPTURE && in_range) begin
                    chan_next  = s_data.channel;
                    cap_next   = TIMER_BITS'(s_data.capture_value);
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ram_we          = 1'b1;
                valid_next[idx] = 1'b1;
                ticks_next      = ticks;
                zero_next       = (ticks == '0);
                if (ticks == '0) begin
                    state_next = ST_HOLD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.out_channel  = chan_reg;
                    m_data_next.period_ticks = ticks_reg;
                    m_data_next.speed_q8     = zero_reg ? '1 : div_quo;
                    m_data_next.zero_period  = zero_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // divider starts the cycle after ST_EXEC, once ticks_reg is loaded
        if (state_reg == ST_DIV && !div_busy && !div_done && !zero_reg) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
            wheel_ovf_reg    <= '0;
            engine_ovf_reg   <= '0;
            wheel_const_reg  <= cpsm_pkg::WHEEL_CONST_RESET;
            engine_const_reg <= cpsm_pkg::ENGINE_CONST_RESET;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (accept && s_data.op == cpsm_pkg::OP_OVERFLOW) begin
                if (s_data.timer_sel == cpsm_pkg::TIMER_ENGINE) begin
                    engine_ovf_reg <= engine_ovf_reg + 1'b1;
                end else begin
                    wheel_ovf_reg <= wheel_ovf_reg + 1'b1;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    cpsm_pkg::REG_WHEEL_CONST: begin
                        wheel_const_reg <= cfg_wdata;
                    end
                    cpsm_pkg::REG_ENGINE_CONST: begin
                        engine_const_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
        chan_reg   <= chan_next;
        cap_reg    <= cap_next;
        ticks_reg  <= ticks_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_period |-> m_data.speed_q8 == '1)
        else $error("zero period without saturated speed");

    a_nonzero_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_period |-> m_data.period_ticks != '0)
        else $error("nonzero flag with zero period");

    a_result_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_HOLD))
        else $error("result loaded outside hold state");

    a_capture_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.op == cpsm_pkg::OP_CAPTURE && in_range
        |=> state_reg == ST_EXEC)
        else $error("capture not followed by entry update");

endmodule

`default_nettype wire

[src/cpsm_ram.sv]
// ----------------------------------------------------------------------------
// cpsm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/cpsm_div.sv]
// ----------------------------------------------------------------------------
// cpsm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cpsm_pkg::DATA_W-1:0] dividend,
    input  wire logic [cpsm_pkg::DATA_W-1:0] divisor,
    output logic                             busy,
    output logic                             done,
    output logic      [cpsm_pkg::DATA_W-1:0] quotient
);

    localparam int unsigned W     = cpsm_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
